// File: rtl/two_list_page_cache_policy_macros.svh
// ---------------------------------------------------------------------------
// two_list_page_cache_policy_macros
// Assertion helpers shared by the page cache policy modules.
// ---------------------------------------------------------------------------
`ifndef TWO_LIST_PAGE_CACHE_POLICY_MACROS_SVH
`define TWO_LIST_PAGE_CACHE_POLICY_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define TLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tlp_pkg.sv
// ---------------------------------------------------------------------------
// tlp_pkg
// Shared widths, result codes, datapath commands and status for the
// two-segment page cache replacement policy.
// ---------------------------------------------------------------------------
package tlp_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned PIN_BITS   = 4;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned KEY_W      = 2 * ID_W;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned OUT_SLOT_W = 6;
  localparam int unsigned IN_DATA_W  = 2 * ID_W;
  localparam int unsigned OUT_DATA_W = OUT_SLOT_W + 2 + 2 * ID_W;

  localparam logic [CFG_W-1:0]    CAP_RESET = CFG_W'(64);
  localparam logic [PIN_BITS-1:0] PIN_MAX   = '1;

  // result status codes
  localparam logic [ST_W-1:0] ST_HOT_HIT     = 3'd0;
  localparam logic [ST_W-1:0] ST_COLD_HIT    = 3'd1;
  localparam logic [ST_W-1:0] ST_MISS_FILL   = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_VICTIM   = 3'd3;
  localparam logic [ST_W-1:0] ST_RELEASED    = 3'd4;
  localparam logic [ST_W-1:0] ST_REL_UNKNOWN = 3'd5;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_SREAD,
    OP_REL,
    OP_HOTHIT,
    OP_REM_S,
    OP_RD_T,
    OP_REM_T,
    OP_PUSH_T,
    OP_PUSH_S,
    OP_WALK_INIT,
    OP_WALK_RD,
    OP_WALK_CHK,
    OP_NOVICT,
    OP_RD_C,
    OP_REM_C,
    OP_FILL
  } op_e;

  // datapath status toward the controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic found_hot;
    logic action_rel;
    logic full;
    logic cold_empty;
    logic need_demote;
    logic pin_zero;
    logic left_one;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/tlp_ctrl.sv
// ---------------------------------------------------------------------------
// tlp_ctrl
// Sequencer for the page cache policy: walks each transaction through key
// scan, list update, victim walk and result hand-off.
// ---------------------------------------------------------------------------
`include "two_list_page_cache_policy_macros.svh"

module tlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tlp_pkg::dp_status_t status_i,
  output tlp_pkg::op_e        op_o
);
  import tlp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_SCAN     = 14'b00000000000010,
    S_SREAD    = 14'b00000000000100,
    S_DECIDE   = 14'b00000000001000,
    S_DEMCHK   = 14'b00000000010000,
    S_REM_T    = 14'b00000000100000,
    S_PUSH_T   = 14'b00000001000000,
    S_PUSH_S   = 14'b00000010000000,
    S_WALK_RD  = 14'b00000100000000,
    S_WALK_CHK = 14'b00001000000000,
    S_RD_C     = 14'b00010000000000,
    S_REM_C    = 14'b00100000000000,
    S_FILL     = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  // next state and command
  always_comb begin
    state_d    = state_q;
    op         = OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op      = OP_LOAD;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (status_i.scan_done) state_d = S_SREAD;
      end
      S_SREAD: begin
        op      = OP_SREAD;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.action_rel) begin
          if (status_i.out_free) begin
            op      = OP_REL;
            state_d = S_IDLE;
          end
        end else if (status_i.found && status_i.found_hot) begin
          if (status_i.out_free) begin
            op      = OP_HOTHIT;
            state_d = S_IDLE;
          end
        end else if (status_i.found) begin
          op      = OP_REM_S;
          state_d = S_DEMCHK;
        end else if (!status_i.full) begin
          if (status_i.out_free) begin
            op      = OP_FILL;
            state_d = S_IDLE;
          end
        end else if (status_i.cold_empty) begin
          if (status_i.out_free) begin
            op      = OP_NOVICT;
            state_d = S_IDLE;
          end
        end else begin
          op      = OP_WALK_INIT;
          state_d = S_WALK_RD;
        end
      end
      S_DEMCHK: begin
        if (status_i.need_demote) begin
          op      = OP_RD_T;
          state_d = S_REM_T;
        end else begin
          state_d = S_PUSH_S;
        end
      end
      S_REM_T: begin
        op      = OP_REM_T;
        state_d = S_PUSH_T;
      end
      S_PUSH_T: begin
        op      = OP_PUSH_T;
        state_d = S_PUSH_S;
      end
      S_PUSH_S: begin
        if (status_i.out_free) begin
          op      = OP_PUSH_S;
          state_d = S_IDLE;
        end
      end
      S_WALK_RD: begin
        op      = OP_WALK_RD;
        state_d = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (status_i.pin_zero) begin
          state_d = S_RD_C;
        end else if (status_i.left_one) begin
          if (status_i.out_free) begin
            op      = OP_NOVICT;
            state_d = S_IDLE;
          end
        end else begin
          op      = OP_WALK_CHK;
          state_d = S_WALK_RD;
        end
      end
      S_RD_C: begin
        op      = OP_RD_C;
        state_d = S_REM_C;
      end
      S_REM_C: begin
        op      = OP_REM_C;
        state_d = S_FILL;
      end
      S_FILL: begin
        if (status_i.out_free) begin
          op      = OP_FILL;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign op_o = op;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TLP_ASSERT_IMP(a_final_needs_room,
    op == OP_REL || op == OP_HOTHIT || op == OP_PUSH_S || op == OP_NOVICT || op == OP_FILL,
    status_i.out_free, "result written while output register busy")
  `TLP_ASSERT_NXT(a_accept_starts_scan, in_valid_i && in_ready_o, state_q == S_SCAN,
    "accepted transaction did not start a key scan")

endmodule

// File: rtl/tlp_dp.sv
// ---------------------------------------------------------------------------
// tlp_dp
// Datapath for the page cache policy: slot memories, segment list heads,
// tails and counts, key scan, victim walk and the result register.
// ---------------------------------------------------------------------------
`include "two_list_page_cache_policy_macros.svh"

module tlp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlp_pkg::op_e                      op_i,
  output tlp_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic [tlp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_action_i,
  input  logic [tlp_pkg::ID_W-1:0]          in_tbl_i,
  input  logic [tlp_pkg::ID_W-1:0]          in_page_id_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [tlp_pkg::ST_W-1:0]          out_status_o,
  output logic [tlp_pkg::OUT_SLOT_W-1:0]    out_slot_o,
  output logic                              out_demoted_o,
  output logic                              out_evicted_o,
  output logic [tlp_pkg::ID_W-1:0]          out_ev_tbl_o,
  output logic [tlp_pkg::ID_W-1:0]          out_ev_page_id_o
);
  import tlp_pkg::*;

  typedef logic [SLOT_W-1:0] slot_t;

  // slot memories
  logic [KEY_W-1:0]    key_mem  [CAPACITY];
  slot_t               next_mem [CAPACITY];
  slot_t               prev_mem [CAPACITY];
  logic                hot_mem  [CAPACITY];
  logic [PIN_BITS-1:0] pin_mem  [CAPACITY];

  // control state
  logic [CFG_W-1:0]    cap_q;
  logic [CAPACITY-1:0] valid_q;
  slot_t               head_q [2];
  slot_t               tail_q [2];
  logic [CNT_W-1:0]    cnt_q  [2];
  logic [CNT_W-1:0]    scan_q;
  logic                cmp_vld_q;
  logic                found_q, free_found_q, dem_q, evict_q, action_q;
  logic                out_valid_q;

  // payload state
  logic [KEY_W-1:0]    key_q, ev_key_q;
  slot_t               cmp_idx_q, s_q, free_q, t_q, c_q;
  logic [CNT_W-1:0]    left_q;
  logic [KEY_W-1:0]    rd_key_q;
  slot_t               rd_next_q, rd_prev_q;
  logic                rd_hot_q;
  logic [PIN_BITS-1:0] rd_pin_q;
  logic [ST_W-1:0]     out_status_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic                out_dem_q, out_ev_q;
  logic [KEY_W-1:0]    out_ev_key_q;

  // effective capacity and occupancy
  logic [CNT_W-1:0] cap_eff, hot_limit;
  logic [CNT_W:0]   occ;
  logic             full, out_free, final_op, key_hit;
  logic [PIN_BITS-1:0] pin_inc;
  slot_t            fill_slot;

  always_comb begin
    if (cap_q < CFG_W'(2)) begin
      cap_eff = CNT_W'(2);
    end else if (cap_q > CFG_W'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign hot_limit = cap_eff >> 1;
  assign occ       = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
  assign full      = occ >= {1'b0, cap_eff};
  assign out_free  = !out_valid_q || out_ready_i;
  assign final_op  = (op_i == OP_REL) || (op_i == OP_HOTHIT) || (op_i == OP_PUSH_S) ||
                     (op_i == OP_NOVICT) || (op_i == OP_FILL);
  assign key_hit   = valid_q[cmp_idx_q] && (rd_key_q == key_q);
  assign pin_inc   = (rd_pin_q == PIN_MAX) ? rd_pin_q : rd_pin_q + 1'b1;
  assign fill_slot = evict_q ? s_q : free_q;

  // status toward the controller
  always_comb begin
    status_o.scan_done   = scan_q == CNT_W'(CAPACITY);
    status_o.found       = found_q;
    status_o.found_hot   = rd_hot_q;
    status_o.action_rel  = action_q;
    status_o.full        = full;
    status_o.cold_empty  = cnt_q[0] == '0;
    status_o.need_demote = (cnt_q[1] >= hot_limit) && (cnt_q[1] != '0);
    status_o.pin_zero    = rd_pin_q == '0;
    status_o.left_one    = left_q == CNT_W'(1);
    status_o.out_free    = out_free;
  end

  // shared read address
  logic  rd_en;
  slot_t rd_addr;
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = s_q;
    case (op_i)
      OP_SCAN: begin
        rd_en   = scan_q < CNT_W'(CAPACITY);
        rd_addr = scan_q[SLOT_W-1:0];
      end
      OP_SREAD: begin
        rd_en   = 1'b1;
        rd_addr = s_q;
      end
      OP_RD_T: begin
        rd_en   = 1'b1;
        rd_addr = tail_q[1];
      end
      OP_WALK_RD, OP_RD_C: begin
        rd_en   = 1'b1;
        rd_addr = c_q;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // list unlink and push selection
  logic  rem_en, push_en, rem_g, push_g;
  slot_t rem_x, push_x;
  always_comb begin
    rem_en  = 1'b0;
    rem_g   = 1'b0;
    rem_x   = s_q;
    push_en = 1'b0;
    push_g  = 1'b0;
    push_x  = s_q;
    case (op_i)
      OP_REM_S:  begin rem_en = 1'b1;  rem_x = s_q; end
      OP_REM_T:  begin rem_en = 1'b1;  rem_x = t_q; rem_g = 1'b1; end
      OP_REM_C:  begin rem_en = 1'b1;  rem_x = c_q; end
      OP_PUSH_T: begin push_en = 1'b1; push_x = t_q; end
      OP_PUSH_S: begin push_en = 1'b1; push_x = s_q; push_g = 1'b1; end
      OP_FILL:   begin push_en = 1'b1; push_x = fill_slot; end
      default:   rem_en = 1'b0;
    endcase
  end

  // memory write ports
  logic                next_we, prev_we, hot_we, pin_we, key_we;
  slot_t               next_wa, next_wd, prev_wa, prev_wd, hot_wa, pin_wa;
  logic                hot_wd;
  logic [PIN_BITS-1:0] pin_wd;
  always_comb begin
    next_we = 1'b0;
    next_wa = rd_prev_q;
    next_wd = rd_next_q;
    prev_we = 1'b0;
    prev_wa = rd_next_q;
    prev_wd = rd_prev_q;
    hot_we  = 1'b0;
    hot_wa  = push_x;
    hot_wd  = push_g;
    pin_we  = 1'b0;
    pin_wa  = s_q;
    pin_wd  = pin_inc;
    key_we  = 1'b0;
    if (rem_en) begin
      if (head_q[rem_g] != rem_x) next_we = 1'b1;
      if (tail_q[rem_g] != rem_x) prev_we = 1'b1;
    end
    if (push_en) begin
      hot_we = 1'b1;
      if (cnt_q[push_g] != '0) begin
        next_we = 1'b1;
        next_wa = push_x;
        next_wd = head_q[push_g];
        prev_we = 1'b1;
        prev_wa = head_q[push_g];
        prev_wd = push_x;
      end
    end
    case (op_i)
      OP_REL: begin
        pin_we = found_q && (rd_pin_q != '0);
        pin_wd = rd_pin_q - 1'b1;
      end
      OP_HOTHIT, OP_REM_S: pin_we = 1'b1;
      OP_FILL: begin
        pin_we = 1'b1;
        pin_wa = fill_slot;
        pin_wd = PIN_BITS'(1);
        key_we = 1'b1;
      end
      default: pin_we = 1'b0;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[fill_slot] <= key_q;
    if (next_we) next_mem[next_wa]  <= next_wd;
    if (prev_we) prev_mem[prev_wa]  <= prev_wd;
    if (hot_we)  hot_mem[hot_wa]    <= hot_wd;
    if (pin_we)  pin_mem[pin_wa]    <= pin_wd;
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_addr];
      rd_next_q <= next_mem[rd_addr];
      rd_prev_q <= prev_mem[rd_addr];
      rd_hot_q  <= hot_mem[rd_addr];
      rd_pin_q  <= pin_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      valid_q      <= '0;
      head_q[0]    <= '0;
      head_q[1]    <= '0;
      tail_q[0]    <= '0;
      tail_q[1]    <= '0;
      cnt_q[0]     <= '0;
      cnt_q[1]     <= '0;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      dem_q        <= 1'b0;
      evict_q      <= 1'b0;
      action_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      // new transaction
      if (op_i == OP_LOAD) begin
        action_q     <= in_action_i;
        scan_q       <= '0;
        cmp_vld_q    <= 1'b0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        dem_q        <= 1'b0;
        evict_q      <= 1'b0;
      end
      // key scan, one slot a cycle
      if (op_i == OP_SCAN) begin
        if (rd_en) scan_q <= scan_q + 1'b1;
        cmp_vld_q <= rd_en;
        if (cmp_vld_q) begin
          if (key_hit && !found_q) found_q <= 1'b1;
          if (!valid_q[cmp_idx_q] && !free_found_q) free_found_q <= 1'b1;
        end
      end
      if (op_i == OP_RD_T) dem_q <= 1'b1;
      if (op_i == OP_REM_C) begin
        evict_q            <= 1'b1;
        valid_q[c_q]       <= 1'b0;
      end
      if (op_i == OP_FILL) valid_q[fill_slot] <= 1'b1;
      // list unlink
      if (rem_en) begin
        if (head_q[rem_g] == rem_x) head_q[rem_g] <= rd_next_q;
        if (tail_q[rem_g] == rem_x) tail_q[rem_g] <= rd_prev_q;
        if (cnt_q[rem_g] != '0) cnt_q[rem_g] <= cnt_q[rem_g] - 1'b1;
      end
      // push at head
      if (push_en) begin
        if (cnt_q[push_g] == '0) tail_q[push_g] <= push_x;
        head_q[push_g] <= push_x;
        cnt_q[push_g]  <= cnt_q[push_g] + 1'b1;
      end
      // result register handshake
      if (final_op) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      key_q    <= {in_tbl_i, in_page_id_i};
      ev_key_q <= '0;
    end
    if (op_i == OP_SCAN) begin
      cmp_idx_q <= scan_q[SLOT_W-1:0];
      if (cmp_vld_q) begin
        if (key_hit && !found_q) s_q <= cmp_idx_q;
        if (!valid_q[cmp_idx_q] && !free_found_q) free_q <= cmp_idx_q;
      end
    end
    if (op_i == OP_RD_T) t_q <= tail_q[1];
    if (op_i == OP_WALK_INIT) begin
      c_q    <= tail_q[0];
      left_q <= cnt_q[0];
    end
    if (op_i == OP_WALK_CHK && rd_pin_q != '0) begin
      c_q    <= rd_prev_q;
      left_q <= left_q - 1'b1;
    end
    if (op_i == OP_REM_C) begin
      s_q      <= c_q;
      ev_key_q <= rd_key_q;
    end
    // result fields
    if (final_op) begin
      out_dem_q    <= 1'b0;
      out_ev_q     <= 1'b0;
      out_ev_key_q <= '0;
      out_slot_q   <= s_q[OUT_SLOT_W-1:0];
      case (op_i)
        OP_REL: begin
          out_status_q <= found_q ? ST_RELEASED : ST_REL_UNKNOWN;
          if (!found_q) out_slot_q <= '0;
        end
        OP_HOTHIT: out_status_q <= ST_HOT_HIT;
        OP_PUSH_S: begin
          out_status_q <= ST_COLD_HIT;
          out_dem_q    <= dem_q;
        end
        OP_NOVICT: begin
          out_status_q <= ST_NO_VICTIM;
          out_slot_q   <= '0;
        end
        default: begin
          out_status_q <= ST_MISS_FILL;
          out_slot_q   <= fill_slot[OUT_SLOT_W-1:0];
          out_ev_q     <= evict_q;
          out_ev_key_q <= ev_key_q;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_slot_o        = out_slot_q;
  assign out_demoted_o     = out_dem_q;
  assign out_evicted_o     = out_ev_q;
  assign out_ev_tbl_o      = out_ev_key_q[KEY_W-1:ID_W];
  assign out_ev_page_id_o  = out_ev_key_q[ID_W-1:0];

  `TLP_ASSERT_IMP(a_occ_bound, 1'b1, occ <= (CNT_W+1)'(CAPACITY),
    "segment counts exceed slot count")
  `TLP_ASSERT_IMP(a_evict_is_fill, out_valid_q && out_ev_q, out_status_q == ST_MISS_FILL,
    "eviction reported on a result that is not a fill")

endmodule

// File: rtl/two_list_page_cache_policy.sv
// ---------------------------------------------------------------------------
// two_list_page_cache_policy
// Segmented LRU (hot and cold lists) replacement policy for a page pool.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per page access or release. tuser[0] is
//   the action (0 access, 1 release), tdata carries the page key.
//   Master channel: one result transaction per input, in order. tuser is
//   the status code, tdata the slot, demote/evict flags and evicted key.
//   Config: cfg_we_i writes capacity_in_use; write only while idle.
// Operation:
//   The block works on one transaction at a time. Every lookup scans the
//   slot key memory one entry a cycle. The result is written after the
//   scan for a release, hot hit or free fill; a cold hit first unlinks
//   its entry, and with demotion also moves the hot tail to the cold list;
//   a miss with eviction first walks the cold list past pinned entries.
//   The next transaction is taken in the cycle after the result write.
// Reset: lists empty, all slots free, capacity 64; the memories need no
//   clearing pass since valid bits and list counts gate every read.
// Stall: a finished result waits in the output register; the next
//   transaction is taken and processed, and holds before its result write.
// ---------------------------------------------------------------------------
module two_list_page_cache_policy (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // [31:0] table number, [63:32] page number
  input  logic [tlp_pkg::IN_DATA_W-1:0]     s_tdata_i,
  // [0] action
  input  logic                              s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [5:0] slot, [6] demoted_valid, [7] evicted_valid,
  // [39:8] evicted table number, [71:40] evicted page number
  output logic [tlp_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  // [2:0] status
  output logic [tlp_pkg::ST_W-1:0]          m_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [tlp_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import tlp_pkg::*;

  op_e                   op;
  dp_status_t            status;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic                  out_dem, out_ev;
  logic [ID_W-1:0]       out_ev_table, out_ev_page;

  // sequencer
  tlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .status_i   (status),
    .op_o       (op)
  );

  // lists, memories and result register
  tlp_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_action_i       (s_tuser_i),
    .in_tbl_i          (s_tdata_i[ID_W-1:0]),
    .in_page_id_i      (s_tdata_i[2*ID_W-1:ID_W]),
    .out_ready_i       (m_tready_i),
    .out_valid_o       (m_tvalid_o),
    .out_status_o      (m_tuser_o),
    .out_slot_o        (out_slot),
    .out_demoted_o     (out_dem),
    .out_evicted_o     (out_ev),
    .out_ev_tbl_o      (out_ev_table),
    .out_ev_page_id_o  (out_ev_page)
  );

  // result packing
  assign m_tdata_o = {out_ev_page, out_ev_table, out_ev, out_dem, out_slot};

endmodule
